### sv/multi_policy_process_picker_macros.svh
// Assertion macros shared by the process picker RTL.
`ifndef MULTI_POLICY_PROCESS_PICKER_MACROS_SVH
`define MULTI_POLICY_PROCESS_PICKER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after its antecedent.
`define MPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mpp_pkg.sv
// Types and constants of the multi-policy process picker.
package mpp_pkg;

  localparam int PID_BITS   = 10;
  localparam int TIME_BITS  = 16;
  localparam int POL_BITS   = 3;
  localparam int QUANT_BITS = 8;
  localparam int LIMIT_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int ALU_W      = TIME_BITS + 1;

  // Policy codes.
  localparam logic [POL_BITS-1:0] POL_FIFO = 3'd0;
  localparam logic [POL_BITS-1:0] POL_SJF  = 3'd1;
  localparam logic [POL_BITS-1:0] POL_STCF = 3'd2;
  localparam logic [POL_BITS-1:0] POL_RR   = 3'd3;
  localparam logic [POL_BITS-1:0] POL_MLFQ = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLICY  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUANTUM = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH    = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MEDIUM  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [QUANT_BITS-1:0] QUANTUM_RST = 8'd5;
  localparam logic [LIMIT_BITS-1:0] HIGH_RST    = 16'd5;
  localparam logic [LIMIT_BITS-1:0] MEDIUM_RST  = 16'd10;

  // MLFQ class keys.
  localparam logic [TIME_BITS-1:0] CLASS_HIGH   = 16'd0;
  localparam logic [TIME_BITS-1:0] CLASS_MEDIUM = 16'd1;
  localparam logic [TIME_BITS-1:0] CLASS_LOW    = 16'd2;

  typedef struct packed {
    logic [PID_BITS-1:0]  entry_pid;
    logic                 entry_blocked;
    logic [TIME_BITS-1:0] entry_total_time;
    logic [TIME_BITS-1:0] entry_executed_time;
    logic                 entry_last;
    logic [TIME_BITS-1:0] current_time;
    logic [PID_BITS-1:0]  running_pid;
    logic                 nothing_running;
  } in_item_t;

  typedef struct packed {
    logic [PID_BITS-1:0] chosen_pid;
    logic                chosen_valid;
  } out_item_t;

  // Result of the shared subtract unit.
  typedef struct packed {
    logic             borrow;
    logic [ALU_W-1:0] diff;
  } alu_res_t;

endpackage

### sv/mpp_alu.sv
// Shared subtract and compare unit of the process picker.
module mpp_alu import mpp_pkg::*; (
  input  logic [ALU_W-1:0] a_i,
  input  logic [ALU_W-1:0] b_i,
  output alu_res_t         res_o
);

  logic [ALU_W:0] wide;

  // One extra bit carries the borrow, which is set when a is below b.
  assign wide = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.borrow = wide[ALU_W];
  assign res_o.diff   = wide[ALU_W-1:0];

endmodule

### sv/multi_policy_process_picker.sv
// Sequence: every entry passes S_IDLE and S_FIN; SJF/STCF/MLFQ entries that are not
// blocked add S_KEY and S_CMP (MLFQ adds S_KEY2 once the executed time reaches the high
// limit), round robin adds S_RR, and S_MOD runs the slice remainder bit by bit when the
// running pid meets its entry. A result is registered from S_FIN of the final entry;
// the final entry holds while an earlier result is stalled.
// Reset (asynchronous, active low) clears the sequencer and loads register defaults.
module multi_policy_process_picker import mpp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_item_t                in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_item_t               out_data_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_wdata_i
);

  `include "multi_policy_process_picker_macros.svh"

  localparam int CNT_BITS = $clog2(TIME_BITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KEY  = 3'd1;
  localparam logic [2:0] S_KEY2 = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_RR   = 3'd4;
  localparam logic [2:0] S_MOD  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_q, state_d;

  logic [POL_BITS-1:0]   policy_q;
  logic [QUANT_BITS-1:0] quantum_q;
  logic [LIMIT_BITS-1:0] high_q, medium_q;

  in_item_t item_q;

  logic                 in_decision_q;
  logic [PID_BITS-1:0]  first_pid_q;
  logic [PID_BITS-1:0]  best_pid_q;
  logic [TIME_BITS-1:0] best_key_q;
  logic                 best_found_q;
  logic                 slice_q;
  logic                 take_next_q;
  logic [PID_BITS-1:0]  rot_pid_q;
  logic                 rot_found_q;

  logic [TIME_BITS-1:0]  key_q;
  logic [QUANT_BITS-1:0] rem_q;
  logic [CNT_BITS-1:0]   cnt_q;

  logic      out_valid_q;
  out_item_t out_data_q;

  logic [ALU_W-1:0] alu_a, alu_b;
  alu_res_t         alu_res;

  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic [QUANT_BITS-1:0] q_eff;
  logic [QUANT_BITS:0]   shifted;
  logic [QUANT_BITS-1:0] rem_next;
  logic                  rr_match;
  out_item_t             result;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_FIN) && item_q.entry_last && out_free;
  assign q_eff      = (quantum_q == '0) ? QUANT_BITS'(1) : quantum_q;

  // Next partial remainder: shift in one bit of the current time, subtract on fit.
  assign shifted  = {rem_q, item_q.current_time[cnt_q]};
  assign rem_next = alu_res.borrow ? shifted[QUANT_BITS-1:0]
                                   : alu_res.diff[QUANT_BITS-1:0];

  // The running pid is recognized only once, before the slice outcome is known.
  assign rr_match = !slice_q && !take_next_q && !rot_found_q &&
                    (item_q.entry_pid == item_q.running_pid);

  // Operand selection for the shared subtractor.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_q)
      S_KEY: begin
        if (policy_q == POL_STCF) begin
          alu_a = ALU_W'(item_q.entry_total_time);
          alu_b = ALU_W'(item_q.entry_executed_time);
        end else if (policy_q == POL_MLFQ) begin
          alu_a = ALU_W'(item_q.entry_executed_time);
          alu_b = ALU_W'(high_q);
        end else begin
          alu_a = ALU_W'(item_q.entry_total_time);
        end
      end
      S_KEY2: begin
        alu_a = ALU_W'(item_q.entry_executed_time);
        alu_b = ALU_W'(medium_q);
      end
      S_CMP: begin
        alu_a = ALU_W'(key_q);
        alu_b = ALU_W'(best_key_q);
      end
      S_MOD: begin
        alu_a = ALU_W'(shifted);
        alu_b = ALU_W'(q_eff);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  mpp_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // Decision outcome, formed from the final entry and the scan state.
  always_comb begin
    result = '0;
    case (policy_q)
      POL_SJF, POL_STCF: begin
        if (item_q.nothing_running) begin
          result = '{chosen_pid: first_pid_q, chosen_valid: 1'b1};
        end else if (best_found_q) begin
          result = '{chosen_pid: best_pid_q, chosen_valid: 1'b1};
        end
      end
      POL_MLFQ: begin
        if (best_found_q) begin
          result = '{chosen_pid: best_pid_q, chosen_valid: 1'b1};
        end
      end
      POL_RR: begin
        if (item_q.nothing_running) begin
          result = '{chosen_pid: first_pid_q, chosen_valid: 1'b1};
        end else if (slice_q) begin
          result = '{chosen_pid: item_q.running_pid, chosen_valid: 1'b1};
        end else if (rot_found_q) begin
          result = '{chosen_pid: rot_pid_q, chosen_valid: 1'b1};
        end else if (take_next_q) begin
          result = '{chosen_pid: first_pid_q, chosen_valid: 1'b1};
        end
      end
      default: begin
        result = '{chosen_pid: first_pid_q, chosen_valid: 1'b1};
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (policy_q == POL_RR) begin
            state_d = S_RR;
          end else if ((policy_q == POL_SJF || policy_q == POL_STCF ||
                        policy_q == POL_MLFQ) && !in_data_i.entry_blocked) begin
            state_d = S_KEY;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_KEY: begin
        if (policy_q == POL_MLFQ && !alu_res.borrow) begin
          state_d = S_KEY2;
        end else begin
          state_d = S_CMP;
        end
      end
      S_KEY2: state_d = S_CMP;
      S_CMP:  state_d = S_FIN;
      S_RR: begin
        if (!(take_next_q && !rot_found_q) && rr_match) begin
          state_d = S_MOD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MOD: begin
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!item_q.entry_last || out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= POL_FIFO;
      quantum_q <= QUANTUM_RST;
      high_q    <= HIGH_RST;
      medium_q  <= MEDIUM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POLICY:  policy_q  <= cfg_wdata_i[POL_BITS-1:0];
        CFG_QUANTUM: quantum_q <= cfg_wdata_i[QUANT_BITS-1:0];
        CFG_HIGH:    high_q    <= cfg_wdata_i[LIMIT_BITS-1:0];
        CFG_MEDIUM:  medium_q  <= cfg_wdata_i[LIMIT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Entry capture and working registers of the shared unit.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    case (state_q)
      S_KEY: begin
        if (policy_q == POL_STCF) begin
          key_q <= alu_res.borrow ? '0 : alu_res.diff[TIME_BITS-1:0];
        end else if (policy_q == POL_MLFQ) begin
          key_q <= CLASS_HIGH;
        end else begin
          key_q <= item_q.entry_total_time;
        end
      end
      S_KEY2: key_q <= alu_res.borrow ? CLASS_MEDIUM : CLASS_LOW;
      S_RR: begin
        rem_q <= '0;
        cnt_q <= CNT_BITS'(TIME_BITS - 1);
      end
      S_MOD: begin
        rem_q <= rem_next;
        cnt_q <= cnt_q - CNT_BITS'(1);
      end
      default: begin
      end
    endcase
  end

  // Scan state across the entries of one decision.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_decision_q <= 1'b0;
      first_pid_q   <= '0;
      best_pid_q    <= '0;
      best_key_q    <= '0;
      best_found_q  <= 1'b0;
      slice_q       <= 1'b0;
      take_next_q   <= 1'b0;
      rot_pid_q     <= '0;
      rot_found_q   <= 1'b0;
    end else begin
      // The first entry of a list opens a fresh decision.
      if (accept && !in_decision_q) begin
        in_decision_q <= 1'b1;
        first_pid_q   <= in_data_i.entry_pid;
        best_pid_q    <= '0;
        best_key_q    <= '0;
        best_found_q  <= 1'b0;
        slice_q       <= 1'b0;
        take_next_q   <= 1'b0;
        rot_pid_q     <= '0;
        rot_found_q   <= 1'b0;
      end
      case (state_q)
        S_CMP: begin
          if (!best_found_q || alu_res.borrow) begin
            best_pid_q   <= item_q.entry_pid;
            best_key_q   <= key_q;
            best_found_q <= 1'b1;
          end
        end
        S_RR: begin
          if (take_next_q && !rot_found_q) begin
            rot_pid_q   <= item_q.entry_pid;
            rot_found_q <= 1'b1;
          end
        end
        S_MOD: begin
          // A zero remainder marks a slice end: hand over to the next entry.
          if (cnt_q == '0) begin
            if (rem_next != '0) begin
              slice_q <= 1'b1;
            end else begin
              take_next_q <= 1'b1;
            end
          end
        end
        S_FIN: begin
          if (item_q.entry_last && out_free) begin
            in_decision_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register; a final entry waits while the previous result is still stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A result is only ever produced by the finishing step of a final entry.
  `MPP_ASSERT(a_out_from_fin, !$rose(out_valid_q) || $past(out_load), "stray result")
  // An empty result carries a zero pid.
  `MPP_ASSERT(a_empty_pid, result.chosen_valid || result.chosen_pid == '0, "pid on empty pick")
  // The rotation target is only taken after a slice end was seen.
  `MPP_ASSERT(a_rot_after_take, !rot_found_q || take_next_q, "rotation pid without slice end")
  // The remainder loop runs all of its bits before finishing.
  `MPP_ASSERT_NEXT(a_mod_runs, state_q == S_MOD && cnt_q != '0, state_q == S_MOD, "loop cut short")

endmodule

### verif/tb_multi_policy_process_picker.sv
// Self-checking testbench for the multi-policy process picker.
module tb_multi_policy_process_picker;
  import mpp_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_COUNT   = 14;
  localparam int PHASE_ENTRIES = 100;
  localparam int TIME_MAX      = (1 << TIME_BITS) - 1;
  localparam int PID_MAX       = (1 << PID_BITS) - 1;
  localparam int PRINT_CAP     = 60;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  in_item_t                in_data_i   = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  out_item_t               out_data_o;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i   = CFG_POLICY;
  logic [CFG_BITS-1:0]     cfg_wdata_i = '0;

  multi_policy_process_picker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Free-running clock, period 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the configuration registers.
  logic [POL_BITS-1:0]   mirror_policy  = POL_FIFO;
  logic [QUANT_BITS-1:0] mirror_quantum = QUANTUM_RST;
  logic [LIMIT_BITS-1:0] mirror_high    = HIGH_RST;
  logic [LIMIT_BITS-1:0] mirror_medium  = MEDIUM_RST;

  // Scan state of the decision being predicted.
  logic                 run_open     = 1'b0;
  logic [PID_BITS-1:0]  head_pid     = '0;
  logic [PID_BITS-1:0]  best_pid     = '0;
  logic [TIME_BITS-1:0] best_key     = '0;
  logic                 best_seen    = 1'b0;
  logic                 keep_running = 1'b0;
  logic                 want_next    = 1'b0;
  logic [PID_BITS-1:0]  next_pid     = '0;
  logic                 next_seen    = 1'b0;

  out_item_t expected_picks[$];
  int        errors     = 0;
  int        cycles     = 0;
  int        stall_left = 0;
  bit        steady     = 1'b0;

  // Keep the earliest candidate with the strictly smallest key.
  function automatic void offer_candidate(logic [PID_BITS-1:0] pid,
                                          logic [TIME_BITS-1:0] key);
    if (!best_seen || key < best_key) begin
      best_pid  = pid;
      best_key  = key;
      best_seen = 1'b1;
    end
  endfunction

  // Advance the prediction by one list entry; returns 1 when a pick is due.
  function automatic bit schedule_entry(input in_item_t e, output out_item_t pick);
    logic [TIME_BITS-1:0] slice;
    logic [TIME_BITS-1:0] remaining;
    logic [TIME_BITS-1:0] level;
    logic                 found;
    logic [PID_BITS-1:0]  pid;
    slice = (mirror_quantum == '0) ? TIME_BITS'(1) : TIME_BITS'(mirror_quantum);
    pick  = '0;
    if (!run_open) begin
      head_pid     = e.entry_pid;
      best_pid     = '0;
      best_key     = '0;
      best_seen    = 1'b0;
      keep_running = 1'b0;
      want_next    = 1'b0;
      next_pid     = '0;
      next_seen    = 1'b0;
      run_open     = 1'b1;
    end

    // Ranking policies consider only entries that are not blocked on I/O.
    remaining = (e.entry_total_time > e.entry_executed_time) ?
                e.entry_total_time - e.entry_executed_time : '0;
    level = (e.entry_executed_time < mirror_high) ? CLASS_HIGH :
            (e.entry_executed_time < mirror_medium) ? CLASS_MEDIUM : CLASS_LOW;
    if (!e.entry_blocked) begin
      case (mirror_policy)
        POL_SJF:  offer_candidate(e.entry_pid, e.entry_total_time);
        POL_STCF: offer_candidate(e.entry_pid, remaining);
        POL_MLFQ: offer_candidate(e.entry_pid, level);
        default: ;
      endcase
    end

    // Round robin tracks the running pid and the entry that follows it.
    if (mirror_policy == POL_RR) begin
      if (want_next && !next_seen) begin
        next_pid  = e.entry_pid;
        next_seen = 1'b1;
      end else if (!keep_running && !want_next && !next_seen &&
                   e.entry_pid == e.running_pid) begin
        if (e.current_time % slice != '0) keep_running = 1'b1;
        else want_next = 1'b1;
      end
    end

    if (!e.entry_last) return 1'b0;
    run_open = 1'b0;
    found    = 1'b0;
    pid      = '0;
    case (mirror_policy)
      POL_SJF, POL_STCF: begin
        if (e.nothing_running) begin
          found = 1'b1;
          pid   = head_pid;
        end else if (best_seen) begin
          found = 1'b1;
          pid   = best_pid;
        end
      end
      POL_MLFQ: begin
        found = best_seen;
        pid   = best_pid;
      end
      POL_RR: begin
        if (e.nothing_running) begin
          found = 1'b1;
          pid   = head_pid;
        end else if (keep_running) begin
          found = 1'b1;
          pid   = e.running_pid;
        end else if (next_seen) begin
          found = 1'b1;
          pid   = next_pid;
        end else if (want_next) begin
          found = 1'b1;
          pid   = head_pid;
        end
      end
      default: begin
        found = 1'b1;
        pid   = head_pid;
      end
    endcase
    pick.chosen_valid = found;
    pick.chosen_pid   = found ? pid : '0;
    return 1'b1;
  endfunction

  function automatic in_item_t make_entry(int pid, bit blocked, int total, int executed,
                                          bit last, int now, int running, bit idle);
    in_item_t e;
    e.entry_pid           = PID_BITS'(pid);
    e.entry_blocked       = blocked;
    e.entry_total_time    = TIME_BITS'(total);
    e.entry_executed_time = TIME_BITS'(executed);
    e.entry_last          = last;
    e.current_time        = TIME_BITS'(now);
    e.running_pid         = PID_BITS'(running);
    e.nothing_running     = idle;
    return e;
  endfunction

  // Idle lengths: mostly short, now and then long.
  function automatic int draw_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int sender_pause();
    if (steady || $urandom_range(0, 99) < 55) return 0;
    return draw_pause();
  endfunction

  task automatic flag_mismatch(input string what);
    if (errors < PRINT_CAP) $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // Offer one entry and hold it until the transfer; valid stays high when the
  // next entry follows at once.
  task automatic send_entry(input in_item_t e);
    out_item_t pick;
    int        pause;
    in_data_i  <= e;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (schedule_entry(e, pick)) expected_picks.push_back(pick);
    pause = sender_pause();
    if (pause > 0) begin
      in_valid_i <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
  endtask

  // Drain all pending picks, then give the block time to finish its entry.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_BITS'(value);
    @(posedge clk_i);
    case (idx)
      CFG_POLICY:  mirror_policy  = POL_BITS'(value);
      CFG_QUANTUM: mirror_quantum = QUANT_BITS'(value);
      CFG_HIGH:    mirror_high    = LIMIT_BITS'(value);
      CFG_MEDIUM:  mirror_medium  = LIMIT_BITS'(value);
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [POL_BITS-1:0] pol, input int quantum,
                            input int high, input int medium_lim);
    wait_idle();
    write_reg(CFG_POLICY, int'(pol));
    write_reg(CFG_QUANTUM, quantum);
    write_reg(CFG_HIGH, high);
    write_reg(CFG_MEDIUM, medium_lim);
    cfg_we_i <= 1'b0;
  endtask

  // Reset defaults: FIFO takes the first entry even when it is blocked.
  task automatic test_fifo_at_reset();
    send_entry(make_entry(PID_MAX, 1, TIME_MAX, TIME_MAX, 1, TIME_MAX, PID_MAX, 1));
  endtask

  // Shortest job: blocked entries skipped, ties go to the earlier entry,
  // nothing eligible gives no pick, nothing running gives the first pid.
  task automatic test_shortest_job();
    set_config(POL_SJF, 5, 5, 10);
    send_entry(make_entry(PID_MAX, 0, TIME_MAX, 0, 0, 100, 1, 0));
    send_entry(make_entry(0, 1, 0, 0, 0, 100, 1, 0));
    send_entry(make_entry(600, 0, 3, 0, 0, 100, 1, 0));
    send_entry(make_entry(601, 0, 3, 0, 1, 100, 1, 0));
    send_entry(make_entry(77, 1, 4, 0, 1, 100, 1, 0));
    send_entry(make_entry(78, 1, 4, 0, 1, 100, 1, 1));
  endtask

  // Shortest remaining: remaining time saturates at zero.
  task automatic test_shortest_remaining();
    set_config(POL_STCF, 5, 5, 10);
    send_entry(make_entry(50, 0, 3, 9, 0, 0, 1, 0));
    send_entry(make_entry(51, 0, 10, 10, 1, 0, 1, 0));
  endtask

  // Round robin: slice end moves to the next entry or wraps, inside a slice
  // the running pid stays, an absent running pid gives no pick, a repeated
  // pid counts once, and nothing running gives the first pid.
  task automatic test_round_robin();
    set_config(POL_RR, 4, 5, 10);
    send_entry(make_entry(11, 1, 0, 0, 0, 8, 12, 0));
    send_entry(make_entry(12, 0, 0, 0, 0, 8, 12, 0));
    send_entry(make_entry(13, 1, 0, 0, 1, 8, 12, 0));
    send_entry(make_entry(11, 0, 0, 0, 0, 8, 12, 0));
    send_entry(make_entry(12, 0, 0, 0, 1, 8, 12, 0));
    send_entry(make_entry(11, 0, 0, 0, 0, 9, 11, 0));
    send_entry(make_entry(12, 0, 0, 0, 1, 9, 11, 0));
    send_entry(make_entry(21, 0, 0, 0, 0, 8, 30, 0));
    send_entry(make_entry(22, 0, 0, 0, 1, 8, 30, 0));
    send_entry(make_entry(7, 0, 0, 0, 0, 4, 7, 0));
    send_entry(make_entry(8, 0, 0, 0, 0, 4, 7, 0));
    send_entry(make_entry(7, 0, 0, 0, 1, 4, 7, 0));
    send_entry(make_entry(5, 1, 0, 0, 1, 4, 7, 1));
  endtask

  // Multilevel: best class wins, blocked skipped, nothing running ignored.
  task automatic test_multilevel();
    set_config(POL_MLFQ, 5, 5, 10);
    send_entry(make_entry(40, 0, 0, 12, 0, 0, 1, 1));
    send_entry(make_entry(41, 1, 0, 0, 0, 0, 1, 1));
    send_entry(make_entry(42, 0, 0, 7, 1, 0, 1, 1));
  endtask

  function automatic logic [TIME_BITS-1:0] draw_time(int slice);
    if ($urandom_range(0, 99) < 50)
      return TIME_BITS'($urandom_range(0, TIME_MAX / slice) * slice);
    return TIME_BITS'($urandom_range(0, TIME_MAX));
  endfunction

  // One decision with random content; a few are loose, with per-entry values
  // of time, running pid and idle flag that disagree.
  task automatic send_random_decision(output int length);
    logic [PID_BITS-1:0]  pids [16];
    logic [TIME_BITS-1:0] base;
    in_item_t             e;
    int                   slice;
    bit                   loose;
    length = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 5) : $urandom_range(6, 16);
    loose  = $urandom_range(0, 99) < 10;
    slice  = (mirror_quantum == '0) ? 1 : int'(mirror_quantum);
    for (int k = 0; k < length; k++)
      pids[k] = ($urandom_range(0, 99) < 70) ? PID_BITS'($urandom_range(0, 7)) :
                                                PID_BITS'($urandom_range(0, PID_MAX));
    e = '0;
    e.running_pid = ($urandom_range(0, 99) < 75) ? pids[$urandom_range(0, length - 1)] :
                                                    PID_BITS'($urandom_range(0, 15));
    e.current_time    = draw_time(slice);
    e.nothing_running = $urandom_range(0, 99) < 15;
    for (int k = 0; k < length; k++) begin
      if (loose && $urandom_range(0, 1) == 1) begin
        e.running_pid     = pids[$urandom_range(0, length - 1)];
        e.current_time    = draw_time(slice);
        e.nothing_running = $urandom_range(0, 99) < 30;
      end
      e.entry_pid        = pids[k];
      e.entry_blocked    = $urandom_range(0, 99) < 25;
      e.entry_total_time = ($urandom_range(0, 99) < 50) ? TIME_BITS'($urandom_range(0, 20)) :
                                                          TIME_BITS'($urandom_range(0, TIME_MAX));
      case ($urandom_range(0, 2))
        0: begin
          base = ($urandom_range(0, 1) == 1) ? mirror_high : mirror_medium;
          e.entry_executed_time = TIME_BITS'(base + $urandom_range(0, 2) - 1);
        end
        1: e.entry_executed_time = TIME_BITS'($urandom_range(0, 20));
        default: e.entry_executed_time = TIME_BITS'($urandom_range(0, TIME_MAX));
      endcase
      e.entry_last = (k == length - 1);
      send_entry(e);
    end
  endtask

  // Random decisions over a series of register settings, extremes included.
  task automatic test_random_mix();
    logic [POL_BITS-1:0] pol;
    int quantum;
    int high;
    int medium_lim;
    int sent;
    int length;
    int rr_phase;
    rr_phase = 0;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase < 8) pol = POL_BITS'(phase);
      else pol = (phase % 3 == 1) ? POL_MLFQ : POL_RR;
      if (pol == POL_RR) begin
        case (rr_phase)
          0: quantum = $urandom_range(2, 12);
          1: quantum = 1;
          2: quantum = 255;
          3: quantum = 0;
          default: quantum = $urandom_range(2, 6);
        endcase
        rr_phase++;
      end else begin
        quantum = $urandom_range(0, 255);
      end
      case (phase % 4)
        0: begin
          high       = 0;
          medium_lim = TIME_MAX;
        end
        1: begin
          high       = TIME_MAX;
          medium_lim = 0;
        end
        2: begin
          high       = $urandom_range(0, 20);
          medium_lim = $urandom_range(0, 30);
        end
        default: begin
          high       = $urandom_range(0, TIME_MAX);
          medium_lim = $urandom_range(0, TIME_MAX);
        end
      endcase
      set_config(pol, quantum, high, medium_lim);
      steady = (phase % 5 == 4);
      sent   = 0;
      while (sent < PHASE_ENTRIES) begin
        send_random_decision(length);
        sent += length;
      end
    end
    steady = 1'b0;
  endtask

  // Receiver side: random stalls, mostly short.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!steady && $urandom_range(0, 99) < 30) begin
      stall_left  <= draw_pause() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each result transfer with the oldest pending pick.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_picks.size() == 0) begin
        flag_mismatch($sformatf("unexpected result pid %0d valid %0b",
                                out_data_o.chosen_pid, out_data_o.chosen_valid));
      end else begin
        want = expected_picks.pop_front();
        if (out_data_o.chosen_pid !== want.chosen_pid)
          flag_mismatch($sformatf("chosen_pid %0d, expected %0d",
                                  out_data_o.chosen_pid, want.chosen_pid));
        if (out_data_o.chosen_valid !== want.chosen_valid)
          flag_mismatch($sformatf("chosen_valid %0b, expected %0b",
                                  out_data_o.chosen_valid, want.chosen_valid));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d picks pending",
               cycles, expected_picks.size());
      $display("** multi_policy_process_picker: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_fifo_at_reset();
    test_shortest_job();
    test_shortest_remaining();
    test_round_robin();
    test_multilevel();
    test_random_mix();
    wait_idle();
    if (errors == 0) begin
      $display("** multi_policy_process_picker: PASSED **");
    end else begin
      $display("** multi_policy_process_picker: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/mpp_pkg.sv
sv/mpp_alu.sv
sv/multi_policy_process_picker.sv
verif/tb_multi_policy_process_picker.sv
